### hdl/vlid_pkg.sv
`default_nettype none
package vlid_pkg;

   // Format codes
   localparam logic [2:0] FMT_LEB128 = 3'd0;
   localparam logic [2:0] FMT_U29    = 3'd1;
   localparam logic [2:0] FMT_LONG   = 3'd2;
   localparam logic [2:0] FMT_FIX16  = 3'd3;
   localparam logic [2:0] FMT_FIX24  = 3'd4;
   localparam logic [2:0] FMT_FIX32  = 3'd5;
   localparam logic [2:0] FMT_FIX64  = 3'd6;

   // Group limits
   localparam logic [3:0] U29_CONT_MAX  = 4'd3;
   localparam logic [3:0] LONG_CONT_MAX = 4'd8;
   localparam logic [3:0] LEB_GROUPS    = 4'd5;
   localparam logic [3:0] COUNT_MAX     = 4'd15;
   localparam logic [63:0] LOW32_MASK   = 64'h0000_0000_FFFF_FFFF;

   // One stream byte with its format code
   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] format;
   } item_type;

   // One decoded value
   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  value_format;
      logic [3:0]  byte_count;
   } result_type;

   // Reverse the low bytes of a fixed word, word size given by format
   function automatic logic [63:0] swap_bytes(input logic [63:0] v, input logic [2:0] fmt);
      logic [63:0] r;
      r = '0;
      unique case (fmt)
         FMT_FIX16: r = {48'd0, v[7:0], v[15:8]};
         FMT_FIX24: r = {40'd0, v[7:0], v[15:8], v[23:16]};
         FMT_FIX32: r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
         default:   r = {v[7:0], v[15:8], v[23:16], v[31:24],
                         v[39:32], v[47:40], v[55:48], v[63:56]};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/vlid_in_stage.sv
`default_nettype none
module vlid_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire vlid_pkg::item_type req_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output vlid_pkg::item_type     item
);
   import vlid_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Take a new byte when the register is empty or drains this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

### hdl/vlid_core.sv
`default_nettype none
module vlid_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire vlid_pkg::item_type item,
   input  wire logic               big_endian,
   output logic                    done,
   output vlid_pkg::result_type    result
);
   import vlid_pkg::*;

   logic        in_value_ff;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  seen_ff;
   logic [2:0]  held_fmt_ff;

   logic [2:0]  cur_fmt;
   logic [63:0] acc_base;
   logic [3:0]  k, lim, word_len, count;
   logic [5:0]  sh7;
   logic [7:0]  b;
   logic        cont;

   // Start a fresh value when idle
   assign cur_fmt  = in_value_ff ? held_fmt_ff : item.format;
   assign acc_base = in_value_ff ? acc_ff : 64'd0;
   assign k        = in_value_ff ? seen_ff : 4'd0;
   assign b        = item.data_byte;
   assign cont     = b[7];
   assign sh7      = 6'(k) * 6'd7;
   assign lim      = (cur_fmt == FMT_U29) ? U29_CONT_MAX : LONG_CONT_MAX;
   assign count    = (k == COUNT_MAX) ? COUNT_MAX : k + 4'd1;

   always_comb begin
      unique case (cur_fmt)
         FMT_FIX16: word_len = 4'd2;
         FMT_FIX24: word_len = 4'd3;
         FMT_FIX32: word_len = 4'd4;
         default:   word_len = 4'd8;
      endcase
   end

   // Fold the byte into the accumulator
   always_comb begin
      acc_in              = acc_base;
      done                = 1'b0;
      result.value        = '0;
      result.value_format = cur_fmt;
      result.byte_count   = count;
      unique case (cur_fmt)
         FMT_LEB128: begin
            if (k < LEB_GROUPS) begin
               acc_in = acc_base | (({57'd0, b[6:0]} << sh7) & LOW32_MASK);
            end
            done         = !cont;
            result.value = acc_in;
         end
         FMT_U29, FMT_LONG: begin
            if (cont && (k < lim)) begin
               acc_in = {acc_base[56:0], b[6:0]};
            end else if (k < lim) begin
               acc_in = {acc_base[56:0], b[6:0]};
               done   = 1'b1;
            end else begin
               acc_in = {acc_base[55:0], b};
               done   = 1'b1;
            end
            result.value = acc_in;
         end
         FMT_FIX16, FMT_FIX24, FMT_FIX32, FMT_FIX64: begin
            if (k < 4'd8) begin
               acc_in = acc_base | ({56'd0, b} << {k[2:0], 3'b000});
            end
            done         = (count >= word_len);
            result.value = big_endian ? swap_bytes(acc_in, cur_fmt) : acc_in;
         end
         default: begin
            acc_in       = {56'd0, b};
            done         = 1'b1;
            result.value = acc_in;
         end
      endcase
   end

   // Hold value state between bytes; clear it when a value completes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff <= 1'b0;
      end else if (advance) begin
         in_value_ff <= !done;
      end
      if (advance) begin
         acc_ff      <= acc_in;
         seen_ff     <= count;
         held_fmt_ff <= cur_fmt;
      end
   end
endmodule
`default_nettype wire

### hdl/vlid_out_stage.sv
`default_nettype none
module vlid_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire vlid_pkg::result_type result,
   output logic                      space,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output vlid_pkg::result_type      rsp_result
);
   import vlid_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   // Room for a result when empty or the current one transfers now
   assign space = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
endmodule
`default_nettype wire

### hdl/variable_length_integer_decoder.sv
`default_nettype none
// Path: input register, then one-pass decode, then result register on rsp.
// Throughput: one byte per cycle unless a finished value waits on rsp_ready; the
// input register, the one-pass decode and the result register each take one item
// per cycle; a byte that completes no value only needs the input register to drain.
// Reset: synchronous, active high; clears all valid flags, drops any partial
// value and sets big_endian to 1.
module variable_length_integer_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [2:0]  req_format,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_value,
   output logic [2:0]       rsp_value_format,
   output logic [3:0]       rsp_byte_count,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);
   import vlid_pkg::*;

   logic       big_endian_ff;
   item_type   req_item, item;
   logic       item_valid, advance, done, space;
   result_type result, rsp_result;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b1;
      end else if (csr_write_enable) begin
         big_endian_ff <= csr_write_data;
      end
   end

   assign req_item.data_byte = req_data_byte;
   assign req_item.format    = req_format;

   // Advance a byte unless it completes a value with no room downstream
   assign advance = item_valid && (!done || space);

   vlid_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vlid_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item),
      .big_endian (big_endian_ff),
      .done       (done),
      .result     (result)
   );

   vlid_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && done),
      .result     (result),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_value        = rsp_result.value;
   assign rsp_value_format = rsp_result.value_format;
   assign rsp_byte_count   = rsp_result.byte_count;
endmodule
`default_nettype wire
